// ===== rtl/core/spq_pkg.sv =====
// Package for the sorted priority queue: beat structs, operation and
// status codes, the cell control struct and default sizes.
// No dependencies.
`default_nettype none

package spq_pkg;

    localparam int unsigned DEPTH_DEF         = 16;
    localparam int unsigned HANDLE_BITS_DEF   = 16;
    localparam int unsigned PRIORITY_BITS_DEF = 16;

    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_PPUSH  = 3'd1;
    localparam logic [2:0] OP_POP    = 3'd2;
    localparam logic [2:0] OP_FIND   = 3'd3;
    localparam logic [2:0] OP_REMOVE = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] node_id;
        logic [31:0] data_tag;
        logic [15:0] priority_req;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_node_id;
        logic [31:0] out_data_tag;
        logic [15:0] out_priority;
        logic [4:0]  entry_count;
    } t_out_beat;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic     cmp;    // evaluate and register the per-cell match flag
        logic     shift;  // apply the insert or remove move
        t_in_beat req;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/sorted_priority_queue_unit.sv =====
// Sorted priority queue built as a chain of entry cells. An input beat is
// registered in the idle state, the cells register their match flags in the
// compare state, and the apply state does first-hit resolution and the shift
// along the chain and registers the result beat. No new beat is taken until
// the controller is back in idle; a stalled result beat holds the apply state.
// Reset clears the entry count and handshake state; entry contents stay
// undefined until written.
`default_nettype none

module sorted_priority_queue_unit #(
    parameter int unsigned DEPTH         = spq_pkg::DEPTH_DEF,
    parameter int unsigned HANDLE_BITS   = spq_pkg::HANDLE_BITS_DEF,
    parameter int unsigned PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  spq_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output spq_pkg::t_out_beat o_out_beat
);
    import spq_pkg::*;

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    // The controller walks idle, compare and apply; each state is one-hot.
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CMP   = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state           r_state, n_state;
    t_in_beat         r_req;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid;
    t_out_beat        r_out;
    t_out_beat        n_out;

    t_cell_ctl        ctl;
    logic             out_free;
    logic             apply;
    logic             full;
    logic             empty;
    logic             found;
    logic             insert_op;

    // Chain wiring: cell outputs and the seen flag that runs head to tail.
    logic [HANDLE_BITS-1:0]   w_handle [DEPTH];
    logic [31:0]              w_tag    [DEPTH];
    logic [PRIORITY_BITS-1:0] w_prio   [DEPTH];
    logic                     w_hit    [DEPTH];
    logic                     w_seen   [DEPTH+1];

    logic [HANDLE_BITS-1:0]   sel_handle;
    logic [31:0]              sel_tag;
    logic [PRIORITY_BITS-1:0] sel_prio;

    // The output register is free when empty or when its beat leaves now.
    assign out_free  = !r_out_valid || !i_out_stall;
    assign apply     = (r_state == S_APPLY) && out_free;
    assign full      = r_count == CNT_W'(DEPTH);
    assign empty     = r_count == '0;
    assign insert_op = (r_req.operation == OP_PUSH) || (r_req.operation == OP_PPUSH);
    assign found     = w_seen[DEPTH];

    assign o_in_stall = r_state != S_IDLE;

    // Only inserts into a list with room and removes actually move entries.
    // A remove with no match leaves every cell in place by itself.
    always_comb begin
        ctl.cmp   = r_state == S_CMP;
        ctl.shift = apply && ((insert_op && !full) || (r_req.operation == OP_REMOVE));
        ctl.req   = r_req;
    end

    assign w_seen[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [HANDLE_BITS-1:0]   left_handle, right_handle;
        logic [31:0]              left_tag, right_tag;
        logic [PRIORITY_BITS-1:0] left_prio, right_prio;

        if (g == 0) begin : g_head
            // The head cell never takes from its left; tie it off.
            assign left_handle = '0;
            assign left_tag    = '0;
            assign left_prio   = '0;
        end else begin : g_mid
            assign left_handle = w_handle[g-1];
            assign left_tag    = w_tag[g-1];
            assign left_prio   = w_prio[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            // After a remove the tail cell falls outside the count.
            assign right_handle = '0;
            assign right_tag    = '0;
            assign right_prio   = '0;
        end else begin : g_body
            assign right_handle = w_handle[g+1];
            assign right_tag    = w_tag[g+1];
            assign right_prio   = w_prio[g+1];
        end

        spq_cell #(
            .IDX           (g),
            .DEPTH         (DEPTH),
            .HANDLE_BITS   (HANDLE_BITS),
            .PRIORITY_BITS (PRIORITY_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (ctl),
            .i_count        (r_count),
            .i_left_handle  (left_handle),
            .i_left_tag     (left_tag),
            .i_left_prio    (left_prio),
            .i_right_handle (right_handle),
            .i_right_tag    (right_tag),
            .i_right_prio   (right_prio),
            .i_seen         (w_seen[g]),
            .o_seen         (w_seen[g+1]),
            .o_hit          (w_hit[g]),
            .o_handle       (w_handle[g]),
            .o_tag          (w_tag[g]),
            .o_prio         (w_prio[g])
        );
    end

    // At most one cell reports the first hit, so an AND-OR picks its entry.
    always_comb begin
        sel_handle = '0;
        sel_tag    = '0;
        sel_prio   = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_hit[i]) begin
                sel_handle = sel_handle | w_handle[i];
                sel_tag    = sel_tag | w_tag[i];
                sel_prio   = sel_prio | w_prio[i];
            end
        end
    end

    // Result and next count. Unknown operation codes report ok with no change.
    always_comb begin
        n_count = r_count;
        n_out   = '0;
        unique case (r_req.operation) inside
            OP_PUSH, OP_PPUSH: begin
                if (full) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_POP: begin
                if (empty) begin
                    n_out.status = ST_EMPTY;
                end else begin
                    n_count            = r_count - CNT_W'(1);
                    n_out.out_node_id  = 16'(sel_handle);
                    n_out.out_data_tag = sel_tag;
                    n_out.out_priority = 16'(sel_prio);
                end
            end
            OP_FIND: begin
                if (!found) begin
                    n_out.status = ST_NOTFOUND;
                end else begin
                    n_out.out_node_id  = 16'(sel_handle);
                    n_out.out_data_tag = sel_tag;
                    n_out.out_priority = 16'(sel_prio);
                end
            end
            OP_REMOVE: begin
                if (!found) begin
                    n_out.status = ST_NOTFOUND;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_out.entry_count = 5'(n_count);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                // Hold here while the previous result beat is still stalled.
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (apply) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_req <= i_in_beat;
        end
        if (apply) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/spq_cell.sv =====
// One cell of the sorted queue chain: holds a single entry and its match flag.
// Depends on spq_pkg.
`default_nettype none

module spq_cell #(
    parameter int unsigned IDX           = 0,
    parameter int unsigned DEPTH         = spq_pkg::DEPTH_DEF,
    parameter int unsigned HANDLE_BITS   = spq_pkg::HANDLE_BITS_DEF,
    parameter int unsigned PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
    localparam int unsigned CNT_W        = $clog2(DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  spq_pkg::t_cell_ctl       i_ctl,
    input  logic [CNT_W-1:0]         i_count,
    input  logic [HANDLE_BITS-1:0]   i_left_handle,
    input  logic [31:0]              i_left_tag,
    input  logic [PRIORITY_BITS-1:0] i_left_prio,
    input  logic [HANDLE_BITS-1:0]   i_right_handle,
    input  logic [31:0]              i_right_tag,
    input  logic [PRIORITY_BITS-1:0] i_right_prio,
    input  logic                     i_seen,
    output logic                     o_seen,
    output logic                     o_hit,
    output logic [HANDLE_BITS-1:0]   o_handle,
    output logic [31:0]              o_tag,
    output logic [PRIORITY_BITS-1:0] o_prio
);
    import spq_pkg::*;

    localparam logic [CNT_W-1:0] C_IDX  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] C_NEXT = CNT_W'(IDX + 1);

    logic [HANDLE_BITS-1:0]   r_handle;
    logic [31:0]              r_tag;
    logic [PRIORITY_BITS-1:0] r_prio;
    logic                     r_match;
    logic                     n_match;
    logic                     occ;
    logic [HANDLE_BITS-1:0]   key_handle;
    logic [PRIORITY_BITS-1:0] key_prio;
    logic                     insert_op;

    assign occ        = C_IDX < i_count;
    assign key_handle = HANDLE_BITS'(i_ctl.req.node_id);
    assign key_prio   = (i_ctl.req.operation == OP_PUSH) ? '0
                                                         : PRIORITY_BITS'(i_ctl.req.priority_req);
    assign insert_op  = (i_ctl.req.operation == OP_PUSH) || (i_ctl.req.operation == OP_PPUSH);

    // The insert position is the first occupied cell that qualifies, or
    // the first free cell when none does.
    always_comb begin
        unique case (i_ctl.req.operation) inside
            OP_PUSH, OP_PPUSH: begin
                n_match = (occ && ((i_ctl.req.operation == OP_PUSH) || (r_prio <= key_prio)))
                          || (i_count == C_IDX);
            end
            OP_POP:    n_match = (i_count == C_NEXT);
            OP_FIND:   n_match = occ && (r_tag == i_ctl.req.data_tag);
            OP_REMOVE: n_match = occ && (r_handle == key_handle);
            default:   n_match = 1'b0;
        endcase
    end

    // First hit along the chain: no cell nearer the head has matched.
    assign o_hit  = r_match && !i_seen;
    assign o_seen = r_match || i_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_match <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            if (insert_op) begin
                if (o_hit) begin
                    r_handle <= key_handle;
                    r_tag    <= i_ctl.req.data_tag;
                    r_prio   <= key_prio;
                end else if (i_seen) begin
                    r_handle <= i_left_handle;
                    r_tag    <= i_left_tag;
                    r_prio   <= i_left_prio;
                end
            end else if (o_seen) begin
                r_handle <= i_right_handle;
                r_tag    <= i_right_tag;
                r_prio   <= i_right_prio;
            end
        end
    end

    assign o_handle = r_handle;
    assign o_tag    = r_tag;
    assign o_prio   = r_prio;

endmodule

`default_nettype wire
